FILE: sv/ebcc_pkg.sv
package ebcc_pkg;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_STOP  = 2'd2;

   // valid bits: input register and six stages
   localparam int STAGES = 7;

   localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
   localparam logic [19:0] EPOCH_SHIFT   = 20'd719468;
   localparam logic [17:0] DAYS_PER_ERA  = 18'd146097;
   localparam logic [17:0] DAYS_PER_CENT = 18'd36524;
   localparam logic [17:0] DAYS_ERA_LAST = 18'd146096;
   localparam logic [11:0] BASE_YEAR     = 12'd2000;
   localparam logic [11:0] LAST_YEAR     = 12'd2099;

   // reciprocals: floor(x / d) == (x * ceil(2^(n+l) / d)) >> (n+l) for n-bit x, 2^l >= d
   localparam int DAY_SHIFT  = 35;
   localparam logic [25:0] DAY_RECIP = 26'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);
   localparam int Q4Y_SHIFT  = 29;
   localparam logic [18:0] Q4Y_RECIP = 19'(((64'd1 << Q4Y_SHIFT) + 64'd1459) / 64'd1460);
   localparam int YEAR_SHIFT = 27;
   localparam logic [18:0] YEAR_RECIP = 19'(((64'd1 << YEAR_SHIFT) + 64'd364) / 64'd365);
   localparam int MIN_SHIFT  = 23;
   localparam logic [17:0] MIN_RECIP = 18'(((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60);
   localparam int HOUR_SHIFT = 17;
   localparam logic [11:0] HOUR_RECIP = 12'(((64'd1 << HOUR_SHIFT) + 64'd59) / 64'd60);
   localparam int WEEK_SHIFT = 19;
   localparam logic [16:0] WEEK_RECIP = 17'(((64'd1 << WEEK_SHIFT) + 64'd6) / 64'd7);
   localparam int MON_SHIFT  = 19;
   localparam logic [11:0] MON_RECIP = 12'(((64'd1 << MON_SHIFT) + 64'd152) / 64'd153);
   localparam int FIVE_SHIFT = 15;
   localparam logic [12:0] FIVE_RECIP = 13'(((64'd1 << FIVE_SHIFT) + 64'd4) / 64'd5);
   localparam int TEN_SHIFT  = 11;
   localparam logic [7:0] TEN_RECIP = 8'(((64'd1 << TEN_SHIFT) + 64'd9) / 64'd10);

   typedef struct packed {
      logic       op;
      logic [31:0] epoch_in;
      logic [7:0] sec_raw;
      logic [7:0] min_raw;
      logic [7:0] hour_raw;
      logic [7:0] day_raw;
      logic [7:0] month_raw;
      logic [7:0] year_raw;
   } req_type;

   typedef struct packed {
      logic [31:0] epoch_out;
      logic [6:0] sec_bcd;
      logic [6:0] min_bcd;
      logic [5:0] hour_bcd;
      logic [5:0] day_bcd;
      logic [2:0] weekday_code;
      logic [4:0] month_bcd;
      logic [7:0] year_bcd;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic        op;
      logic        stop;
      logic [31:0] epoch;
      logic [15:0] days;
      logic [16:0] tod;
      logic [17:0] doe;
      logic [2:0]  era;
      logic [17:0] n;
      logic [10:0] mt;
      logic [12:0] wq;
      logic [8:0]  yoe;
      logic [5:0]  sec;
      logic [4:0]  hr;
      logic [2:0]  wk;
      logic [8:0]  doy;
      logic [5:0]  mn;
      logic [11:0] y0;
      logic [3:0]  mp;
      logic [5:0]  dday;
      logic [8:0]  dyoe;
      logic        dera5;
      logic [4:0]  didx;
      logic [9:0]  tb;
      logic [17:0] tsec;
      logic [31:0] cpart;
   } pipe_type;

   function automatic logic [7:0] bcd_enc(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  units;
      prod  = 15'(v) * 15'(TEN_RECIP);
      tens  = prod[14:11];
      units = v - 7'(tens) * 7'd10;
      return {tens, units[3:0]};
   endfunction

   function automatic logic [7:0] bcd_dec(input logic [7:0] v);
      return 8'(v[7:4]) * 8'd10 + 8'(v[3:0]);
   endfunction

   // (153 * idx + 2) / 5
   function automatic logic [9:0] month_start(input logic [4:0] idx);
      logic [11:0] v;
      logic [24:0] prod;
      v    = 12'(idx) * 12'd153 + 12'd2;
      prod = 25'(v) * 25'(FIVE_RECIP);
      return prod[24:15];
   endfunction

   function automatic logic [1:0] century_of(input logic [8:0] yoe);
      return 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
   endfunction

endpackage

FILE: sv/epoch_bcd_calendar_converter.sv
// throughput: one request per cycle unless rsp_ready stalls, set by the 8-register pipeline
//    of constant reciprocal multiplies (input register, six stages, response register)
// each stage takes new data when empty or when its content moves on
// reset clears every stage valid bit; data registers are not reset
module epoch_bcd_calendar_converter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ebcc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ebcc_pkg::rsp_type rsp_data
);
   import ebcc_pkg::*;

   logic [STAGES-1:0] valid_ff, valid_in, take;
   logic              rsp_valid_ff, rsp_take;

   req_type  req_ff;
   pipe_type st1_ff, st1_in, st2_ff, st2_in, st3_ff, st3_in;
   pipe_type st4_ff, st4_in, st5_ff, st5_in, st6_ff, st6_in;
   rsp_type  rsp_ff, rsp_in;

   // flow control
   assign rsp_take = !rsp_valid_ff || rsp_ready;
   always_comb begin
      take[STAGES-1] = !valid_ff[STAGES-1] || rsp_take;
      for (int i = STAGES - 2; i >= 0; i--) begin
         take[i] = !valid_ff[i] || take[i+1];
      end
      valid_in[0] = take[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = take[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   assign req_ready = take[0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // stage 1: day count, bcd decode
   logic [50:0] day_prod;
   logic [6:0]  d_sec, d_min;
   logic [5:0]  d_hour;
   logic [4:0]  d_mon;
   logic [7:0]  d_year;
   logic        d_early;
   always_comb begin
      day_prod = 51'(req_ff.epoch_in[31:7]) * 51'(DAY_RECIP);
      d_sec    = 7'(bcd_dec({1'b0, req_ff.sec_raw[6:0]}));
      d_min    = 7'(bcd_dec({1'b0, req_ff.min_raw[6:0]}));
      d_hour   = 6'(bcd_dec({2'b0, req_ff.hour_raw[5:0]}));
      d_mon    = 5'(bcd_dec({3'b0, req_ff.month_raw[4:0]}));
      d_year   = bcd_dec(req_ff.year_raw);
      d_early  = d_mon <= 5'd2;
      st1_in       = '0;
      st1_in.op    = req_ff.op;
      st1_in.stop  = req_ff.sec_raw[7];
      st1_in.epoch = req_ff.epoch_in;
      st1_in.days  = day_prod[50:35];
      st1_in.dday  = 6'(bcd_dec({2'b0, req_ff.day_raw[5:0]}));
      if (d_year == 8'd0 && d_early) begin
         st1_in.dera5 = 1'b0;
         st1_in.dyoe  = 9'd399;
      end else begin
         st1_in.dera5 = 1'b1;
         st1_in.dyoe  = 9'(d_year) - 9'(d_early);
      end
      st1_in.didx = d_early ? d_mon + 5'd9 : d_mon - 5'd3;
      st1_in.tsec = 18'(d_hour) * 18'd3600 + 18'(d_min) * 18'd60 + 18'(d_sec);
   end

   // stage 2: time of day, era, day of era, decode month start and day count
   logic [19:0] z;
   always_comb begin
      st2_in = st1_ff;
      st2_in.tod = 17'(st1_ff.epoch - 32'(st1_ff.days) * 32'(SEC_PER_DAY));
      z = 20'(st1_ff.days) + EPOCH_SHIFT;
      st2_in.era = '0;
      for (int k = 1; k <= 5; k++) begin
         if (z >= 20'(k) * 20'(DAYS_PER_ERA)) begin
            st2_in.era = st2_in.era + 3'd1;
         end
      end
      st2_in.doe = 18'(z - 20'(st2_in.era) * 20'(DAYS_PER_ERA));
      st2_in.tb  = month_start(st1_ff.didx);
      st2_in.cpart = (st1_ff.dera5 ? 32'(5 * 146097) : 32'(4 * 146097))
                   + 32'(st1_ff.dyoe) * 32'd365 + 32'(st1_ff.dyoe[8:2])
                   - 32'(century_of(st1_ff.dyoe)) + 32'(st1_ff.dday) - 32'd1
                   - 32'(EPOCH_SHIFT);
   end

   // stage 3
   logic [36:0] q4y_prod;
   logic [34:0] mt_prod;
   logic [32:0] wq_prod;
   logic [2:0]  q_cent;
   always_comb begin
      st3_in   = st2_ff;
      q4y_prod = 37'(st2_ff.doe) * 37'(Q4Y_RECIP);
      q_cent   = '0;
      for (int k = 1; k <= 4; k++) begin
         if (st2_ff.doe >= 18'(k) * DAYS_PER_CENT) begin
            q_cent = q_cent + 3'd1;
         end
      end
      st3_in.n = st2_ff.doe - 18'(q4y_prod[35:29]) + 18'(q_cent)
               - 18'(st2_ff.doe == DAYS_ERA_LAST);
      mt_prod  = 35'(st2_ff.tod) * 35'(MIN_RECIP);
      st3_in.mt = mt_prod[33:23];
      wq_prod  = 33'(st2_ff.days + 16'd4) * 33'(WEEK_RECIP);
      st3_in.wq = wq_prod[31:19];
      st3_in.cpart = st2_ff.cpart + 32'(st2_ff.tb);
   end

   // stage 4
   logic [36:0] yoe_prod;
   logic [22:0] hr_prod;
   always_comb begin
      st4_in   = st3_ff;
      yoe_prod = 37'(st3_ff.n) * 37'(YEAR_RECIP);
      st4_in.yoe = yoe_prod[35:27];
      st4_in.sec = 6'(st3_ff.tod - 17'(st3_ff.mt) * 17'd60);
      hr_prod  = 23'(st3_ff.mt) * 23'(HOUR_RECIP);
      st4_in.hr = hr_prod[21:17];
      st4_in.wk = 3'((st3_ff.days + 16'd4) - 16'(st3_ff.wq) * 16'd7);
      st4_in.epoch = st3_ff.cpart * 32'(SEC_PER_DAY) + 32'(st3_ff.tsec);
   end

   // stage 5
   always_comb begin
      st5_in = st4_ff;
      st5_in.doy = 9'(st4_ff.doe - (18'(st4_ff.yoe) * 18'd365 + 18'(st4_ff.yoe[8:2])
                 - 18'(century_of(st4_ff.yoe))));
      st5_in.mn  = 6'(st4_ff.mt - 11'(st4_ff.hr) * 11'd60);
      st5_in.y0  = 12'(st4_ff.yoe) + 12'(st4_ff.era) * 12'd400;
   end

   // stage 6
   logic [22:0] mp_prod;
   always_comb begin
      st6_in  = st5_ff;
      mp_prod = 23'(11'(st5_ff.doy) * 11'd5 + 11'd2) * 23'(MON_RECIP);
      st6_in.mp = mp_prod[22:19];
   end

   // response stage
   logic [9:0]  day_full;
   logic [3:0]  mon;
   logic [11:0] year;
   always_comb begin
      day_full = 10'(st6_ff.doy) - month_start({1'b0, st6_ff.mp}) + 10'd1;
      mon  = (st6_ff.mp < 4'd10) ? st6_ff.mp + 4'd3 : st6_ff.mp - 4'd9;
      year = st6_ff.y0 + 12'(mon <= 4'd2);
      rsp_in = '0;
      if (st6_ff.op == OP_ENCODE) begin
         if (year < BASE_YEAR || year > LAST_YEAR) begin
            rsp_in.status = STATUS_RANGE;
         end else begin
            rsp_in.sec_bcd      = 7'(bcd_enc({1'b0, st6_ff.sec}));
            rsp_in.min_bcd      = 7'(bcd_enc({1'b0, st6_ff.mn}));
            rsp_in.hour_bcd     = 6'(bcd_enc(7'(st6_ff.hr)));
            rsp_in.day_bcd      = 6'(bcd_enc(7'(day_full[4:0])));
            rsp_in.weekday_code = st6_ff.wk;
            rsp_in.month_bcd    = 5'(bcd_enc(7'(mon)));
            rsp_in.year_bcd     = bcd_enc(7'(year - BASE_YEAR));
            rsp_in.status       = STATUS_OK;
         end
      end else begin
         if (st6_ff.stop) begin
            rsp_in.status = STATUS_STOP;
         end else begin
            rsp_in.epoch_out = st6_ff.epoch;
            rsp_in.status    = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_take ? valid_ff[STAGES-1] : rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take[0]) req_ff <= req_data;
      if (take[1]) st1_ff <= st1_in;
      if (take[2]) st2_ff <= st2_in;
      if (take[3]) st3_ff <= st3_in;
      if (take[4]) st4_ff <= st4_in;
      if (take[5]) st5_ff <= st5_in;
      if (take[6]) st6_ff <= st6_in;
      if (rsp_take) rsp_ff <= rsp_in;
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ebcc_pkg::*;

   localparam int unsigned STUCK_LIMIT = 2000;
   localparam int unsigned LONG_HOLD   = 300;
   localparam int unsigned DRAIN_WAIT  = 20;
   localparam logic [31:0] EPOCH_2000  = 32'd946684800;
   localparam logic [31:0] EPOCH_2100  = 32'd4102444800;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type     expected_regs[$];
   rsp_type     oldest;
   int unsigned error_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   int unsigned hold_count = 0;
   int unsigned stuck_cycles = 0;

   epoch_bcd_calendar_converter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [7:0] to_bcd(input int unsigned v);
      return 8'(((v / 10) << 4) | (v % 10));
   endfunction

   function automatic int unsigned bcd_value(input logic [7:0] v);
      return 32'(v[7:4]) * 10 + 32'(v[3:0]);
   endfunction

   function automatic rsp_type calendar_convert(input req_type r);
      rsp_type     res;
      int unsigned days, tod, z, era, doe, yoe, doy, mp;
      int unsigned yr, mo, dd, zy, zm, k, j, wd;
      int unsigned s, mi, hr, yy;
      res = '0;
      if (r.op == OP_ENCODE) begin
         days = r.epoch_in / 86400;
         tod  = r.epoch_in % 86400;
         z    = days + 719468;
         era  = z / 146097;
         doe  = z - era * 146097;
         yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
         doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
         mp   = (5 * doy + 2) / 153;
         dd   = doy - (153 * mp + 2) / 5 + 1;
         mo   = (mp < 10) ? mp + 3 : mp - 9;
         yr   = yoe + era * 400 + ((mo <= 2) ? 1 : 0);
         if (yr < 2000 || yr > 2099) begin
            res.status = STATUS_RANGE;
         end else begin
            zm = mo;
            zy = yr;
            if (zm < 3) begin
               zm = zm + 12;
               zy = zy - 1;
            end
            k  = zy % 100;
            j  = zy / 100;
            wd = (dd + (13 * (zm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
            res.sec_bcd      = 7'(to_bcd(tod % 60));
            res.min_bcd      = 7'(to_bcd((tod / 60) % 60));
            res.hour_bcd     = 6'(to_bcd(tod / 3600));
            res.day_bcd      = 6'(to_bcd(dd));
            res.weekday_code = 3'((wd + 6) % 7);
            res.month_bcd    = 5'(to_bcd(mo));
            res.year_bcd     = to_bcd(yr - 2000);
            res.status       = STATUS_OK;
         end
      end else if (r.sec_raw[7]) begin
         res.status = STATUS_STOP;
      end else begin
         s   = bcd_value(r.sec_raw & 8'h7F);
         mi  = bcd_value(r.min_raw & 8'h7F);
         hr  = bcd_value(r.hour_raw & 8'h3F);
         dd  = bcd_value(r.day_raw & 8'h3F);
         mo  = bcd_value(r.month_raw & 8'h1F);
         yy  = bcd_value(r.year_raw);
         yr  = 2000 + yy;
         if (mo <= 2) begin
            yr = yr - 1;
         end
         era  = yr / 400;
         yoe  = yr - era * 400;
         doy  = (153 * ((mo > 2) ? mo - 3 : mo + 9) + 2) / 5 + dd - 1;
         doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
         days = era * 146097 + doe - 719468;
         res.epoch_out = days * 86400 + (hr * 3600 + mi * 60 + s);
         res.status    = STATUS_OK;
      end
      return res;
   endfunction

   function automatic req_type encode_request(input logic [31:0] epoch);
      req_type r;
      r.op        = OP_ENCODE;
      r.epoch_in  = epoch;
      r.sec_raw   = 8'($urandom());
      r.min_raw   = 8'($urandom());
      r.hour_raw  = 8'($urandom());
      r.day_raw   = 8'($urandom());
      r.month_raw = 8'($urandom());
      r.year_raw  = 8'($urandom());
      return r;
   endfunction

   function automatic req_type decode_request(input logic [7:0] s, input logic [7:0] mi,
                                              input logic [7:0] h, input logic [7:0] d,
                                              input logic [7:0] mo, input logic [7:0] y);
      req_type r;
      r.op        = OP_DECODE;
      r.epoch_in  = $urandom();
      r.sec_raw   = s;
      r.min_raw   = mi;
      r.hour_raw  = h;
      r.day_raw   = d;
      r.month_raw = mo;
      r.year_raw  = y;
      return r;
   endfunction

   function automatic req_type random_conversion();
      req_type     r;
      int unsigned pick;
      logic [31:0] base;
      r.op        = 1'($urandom_range(1));
      r.epoch_in  = $urandom();
      r.sec_raw   = 8'($urandom());
      r.min_raw   = 8'($urandom());
      r.hour_raw  = 8'($urandom());
      r.day_raw   = 8'($urandom());
      r.month_raw = 8'($urandom());
      r.year_raw  = 8'($urandom());
      pick = $urandom_range(99);
      if (r.op == OP_ENCODE) begin
         if (pick < 60) begin
            r.epoch_in = $urandom_range(EPOCH_2100 - 1, EPOCH_2000);
         end else if (pick < 85) begin
            case ($urandom_range(4))
               0: base = EPOCH_2000;
               1: base = EPOCH_2100;
               2: base = 32'd951782400;
               3: base = 32'h8000_0000;
               default: base = 32'd4078944000;
            endcase
            r.epoch_in = base + $urandom_range(400000) - 200000;
         end
      end else if (pick < 75) begin
         r.sec_raw   = to_bcd($urandom_range(59));
         r.min_raw   = to_bcd($urandom_range(59));
         r.hour_raw  = to_bcd($urandom_range(23));
         r.day_raw   = to_bcd($urandom_range(31, 1));
         r.month_raw = to_bcd($urandom_range(12, 1));
         r.year_raw  = to_bcd($urandom_range(99));
         if ($urandom_range(19) == 0) begin
            r.sec_raw[7] = 1'b1;
         end
         if ($urandom_range(3) == 0) begin
            r.min_raw[7]     = 1'($urandom_range(1));
            r.hour_raw[7:6]  = 2'($urandom_range(3));
            r.day_raw[7:6]   = 2'($urandom_range(3));
            r.month_raw[7:5] = 3'($urandom_range(7));
         end
      end
      return r;
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   task automatic send_request(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      expected_regs.push_back(calendar_convert(item));
   endtask

   // receiver side: random stalls, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_count != 0) begin
         rsp_ready  <= 1'b0;
         hold_count <= hold_count - 1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_count  <= LONG_HOLD;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_regs.size() == 0) begin
            report_error($sformatf("unexpected response %h", rsp_data));
         end else begin
            oldest = expected_regs.pop_front();
            if (rsp_data.epoch_out !== oldest.epoch_out ||
                rsp_data.sec_bcd !== oldest.sec_bcd ||
                rsp_data.min_bcd !== oldest.min_bcd ||
                rsp_data.hour_bcd !== oldest.hour_bcd ||
                rsp_data.day_bcd !== oldest.day_bcd ||
                rsp_data.weekday_code !== oldest.weekday_code ||
                rsp_data.month_bcd !== oldest.month_bcd ||
                rsp_data.year_bcd !== oldest.year_bcd ||
                rsp_data.status !== oldest.status) begin
               report_error($sformatf({"mismatch: expected epoch %h s %h m %h h %h d %h w %h",
                  " mo %h y %h st %h, got epoch %h s %h m %h h %h d %h w %h mo %h y %h st %h"},
                  oldest.epoch_out, oldest.sec_bcd, oldest.min_bcd, oldest.hour_bcd,
                  oldest.day_bcd, oldest.weekday_code, oldest.month_bcd, oldest.year_bcd,
                  oldest.status, rsp_data.epoch_out, rsp_data.sec_bcd, rsp_data.min_bcd,
                  rsp_data.hour_bcd, rsp_data.day_bcd, rsp_data.weekday_code,
                  rsp_data.month_bcd, rsp_data.year_bcd, rsp_data.status));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   task automatic test_encode_directed();
      send_request(encode_request(32'd0));
      send_request(encode_request(EPOCH_2000 - 1));
      send_request(encode_request(EPOCH_2000));
      send_request(encode_request(32'd951782400));
      send_request(encode_request(32'd951868799));
      send_request(encode_request(32'd1234567890));
      send_request(encode_request(32'h7FFF_FFFF));
      send_request(encode_request(32'h8000_0000));
      send_request(encode_request(EPOCH_2100 - 1));
      send_request(encode_request(EPOCH_2100));
      send_request(encode_request(32'hFFFF_FFFF));
   endtask

   task automatic test_decode_directed();
      send_request(decode_request(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(decode_request(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00));
      send_request(decode_request(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00));
      send_request(decode_request(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00));
      send_request(decode_request(8'h08, 8'h14, 8'h03, 8'h19, 8'h01, 8'h38));
      send_request(decode_request(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99));
      send_request(decode_request(8'h30, 8'hD9, 8'hE3, 8'hC1, 8'hE1, 8'h38));
      send_request(decode_request(8'h15, 8'h30, 8'h12, 8'h00, 8'h13, 8'h50));
      send_request(decode_request(8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_request(decode_request(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(decode_request(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
   endtask

   task automatic test_random_traffic(input int unsigned count, input int unsigned send_pct,
                                      input int unsigned recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct <= recv_pct;
      repeat (count) begin
         send_request(random_conversion());
      end
   endtask

   task automatic test_full_pipeline_stall();
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      hold_requests <= hold_requests + 1;
      repeat (64) begin
         send_request(random_conversion());
      end
   endtask

   task automatic finish_run();
      req_valid <= 1'b0;
      while (expected_regs.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   endtask

   initial begin
      send_idle_pct = 38;
      recv_idle_pct <= 45;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_encode_directed();
      test_decode_directed();
      test_random_traffic(540, 38, 45);
      test_random_traffic(540, 45, 38);
      test_full_pipeline_stall();
      test_random_traffic(540, 0, 0);
      finish_run();
   end

endmodule

FILE: sim.f
sv/ebcc_pkg.sv
sv/epoch_bcd_calendar_converter.sv
tb/testbench.sv
